### rtl/bket_pkg.sv
// Shared types and constants for the box kernel ellipsoid test unit.
`default_nettype none
package bket_pkg;

	localparam int BW_W          = 32;
	localparam int KF_W          = 32;
	localparam int ACC_W         = 32;
	localparam int ACC_FRAC      = 24;
	localparam int QUOT_INT_BITS = 4;
	localparam int QUOT_BITS     = QUOT_INT_BITS + ACC_FRAC;
	localparam int SQ_W          = 2 * QUOT_BITS;
	localparam int DIV_STEPS     = QUOT_BITS;
	localparam int DIV_CNT_W     = $clog2(DIV_STEPS);
	localparam int CFG_IDX_W     = 8;

	localparam logic [ACC_W-1:0] ACC_ONE   = 32'h0100_0000;
	localparam logic [ACC_W-1:0] ACC_MAX   = 32'hFFFF_FFFF;
	localparam logic [KF_W-1:0]  KF_RESET  = 32'h0001_0000;

	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_FACTOR = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY      = 8'd1;

	typedef struct packed {
		logic load_in;
		logic mul;
		logic prep;
		logic chk;
		logic div_step;
		logic sqr;
		logic acc;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic sel;
		logic last;
		logic sat;
		logic out_valid;
		logic out_ready;
	} status_t;

endpackage
`default_nettype wire

### rtl/bket_ctrl.sv
// Controller state machine sequencing one dimension through the datapath.
`default_nettype none
module bket_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire bket_pkg::status_t  sts,
	output bket_pkg::cmd_t          cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_PREP = 3'd2;
	localparam logic [2:0] S_CHK  = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_SQR  = 3'd5;
	localparam logic [2:0] S_ACC  = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	localparam logic [bket_pkg::DIV_CNT_W-1:0] CNT_LAST =
		bket_pkg::DIV_CNT_W'(bket_pkg::DIV_STEPS - 1);

	logic [2:0]                     state_q, state_d;
	logic [bket_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           out_free;

	assign s_tready = (state_q == S_IDLE);
	assign out_free = !sts.out_valid || sts.out_ready;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				if (sts.sel) state_d = S_PREP;
				else if (sts.last) state_d = S_DONE;
				else state_d = S_IDLE;
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_CHK;
			end
			S_CHK: begin
				cmd.chk = 1'b1;
				state_d = sts.sat ? S_ACC : S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_LAST) state_d = S_SQR;
			end
			S_SQR: begin
				cmd.sqr = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = sts.last ? S_DONE : S_IDLE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIV) cnt_q <= cnt_q + 1'b1;
			else cnt_q <= '0;
		end
	end

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command at once");

	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free)
		else $error("result loaded over a pending beat");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (cnt_q <= CNT_LAST))
		else $error("division step counter overran");

	a_div_to_sqr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && cnt_q == CNT_LAST) |=> (state_q == S_SQR))
		else $error("division did not end after its last step");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (state_q == S_IDLE && s_tready))
		else $error("not ready after result load");

endmodule
`default_nettype wire

### rtl/bket_datapath.sv
// Datapath: offset magnitude, scaled bandwidth, radix-2 division, square, accumulate.
`default_nettype none
module bket_datapath #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire bket_pkg::cmd_t                  cmd,
	output bket_pkg::status_t                    sts,
	input  wire logic [COORD_WIDTH-1:0]          point_coord,
	input  wire logic [COORD_WIDTH-1:0]          center_coord,
	input  wire logic [bket_pkg::BW_W-1:0]       bandwidth,
	input  wire logic                            selected,
	input  wire logic                            last_dim,
	input  wire logic                            cfg_valid,
	input  wire logic [bket_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bket_pkg::KF_W-1:0]       cfg_data,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 inside_res,
	output logic [bket_pkg::ACC_W-1:0]           dist_squared
);

	localparam int MAG_W  = COORD_WIDTH + 1;
	localparam int PROD_W = bket_pkg::BW_W + bket_pkg::KF_W;
	localparam int S_W    = PROD_W - FRAC_BITS;
	localparam int D_W    = S_W + bket_pkg::QUOT_INT_BITS;
	localparam int R_W    = D_W + 1;
	localparam int CMP_W  = (MAG_W > D_W) ? MAG_W : D_W;
	localparam int QB     = bket_pkg::QUOT_BITS;

	logic [bket_pkg::KF_W-1:0]  kf_q;
	logic                       incl_q;
	logic [MAG_W-1:0]           mag_q;
	logic [bket_pkg::BW_W-1:0]  bw_q;
	logic                       sel_q, last_q, sat_q;
	logic [PROD_W-1:0]          prod_q;
	logic [S_W-1:0]             div_q;
	logic [R_W-1:0]             r_q;
	logic [QB-1:0]              quot_q;
	logic [bket_pkg::SQ_W-1:0]  sq_q;
	logic [bket_pkg::ACC_W-1:0] acc_q;
	logic                       out_valid_q, inside_q;
	logic [bket_pkg::ACC_W-1:0] dist_q;

	logic [MAG_W-1:0]           diff_c, mag_c;
	logic [S_W-1:0]             s_c;
	logic [D_W-1:0]             dshift_c;
	logic                       sat_c;
	logic [R_W-1:0]             r2_c, dext_c;
	logic                       ge_c;
	logic [bket_pkg::ACC_W-1:0] term_c;
	logic [bket_pkg::ACC_W:0]   sum_c;

	assign diff_c   = {point_coord[COORD_WIDTH-1], point_coord}
	                - {center_coord[COORD_WIDTH-1], center_coord};
	assign mag_c    = diff_c[MAG_W-1] ? (~diff_c + 1'b1) : diff_c;
	assign s_c      = prod_q[PROD_W-1:FRAC_BITS];
	assign dshift_c = {div_q, {bket_pkg::QUOT_INT_BITS{1'b0}}};
	assign sat_c    = (CMP_W'(mag_q) >= CMP_W'(dshift_c));
	assign r2_c     = {r_q[R_W-2:0], 1'b0};
	assign dext_c   = {1'b0, dshift_c};
	assign ge_c     = (r2_c >= dext_c);
	assign term_c   = sat_q ? bket_pkg::ACC_MAX
	                        : sq_q[bket_pkg::SQ_W-1:bket_pkg::ACC_FRAC];
	assign sum_c    = {1'b0, acc_q} + {1'b0, term_c};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kf_q        <= bket_pkg::KF_RESET;
			incl_q      <= 1'b0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			sel_q       <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					bket_pkg::REG_KERNEL_FACTOR: kf_q <= cfg_data;
					bket_pkg::REG_BOUNDARY:      incl_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.load_in) begin
				sel_q  <= selected;
				last_q <= last_dim;
			end
			if (cmd.acc) acc_q <= sum_c[bket_pkg::ACC_W] ? bket_pkg::ACC_MAX
			                                             : sum_c[bket_pkg::ACC_W-1:0];
			else if (cmd.out_load) acc_q <= '0;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			mag_q <= mag_c;
			bw_q  <= bandwidth;
		end
		if (cmd.mul) prod_q <= PROD_W'(bw_q) * PROD_W'(kf_q);
		if (cmd.prep) div_q <= (s_c == '0) ? S_W'(1) : s_c;
		if (cmd.chk) begin
			sat_q  <= sat_c;
			r_q    <= R_W'(mag_q);
			quot_q <= '0;
		end
		if (cmd.div_step) begin
			r_q    <= ge_c ? (r2_c - dext_c) : r2_c;
			quot_q <= {quot_q[QB-2:0], ge_c};
		end
		if (cmd.sqr) sq_q <= bket_pkg::SQ_W'(quot_q) * bket_pkg::SQ_W'(quot_q);
		if (cmd.out_load) begin
			dist_q   <= acc_q;
			inside_q <= incl_q ? (acc_q < bket_pkg::ACC_ONE) : (acc_q <= bket_pkg::ACC_ONE);
		end
	end

	assign sts.sel       = sel_q;
	assign sts.last      = last_q;
	assign sts.sat       = sat_c;
	assign sts.out_valid = out_valid_q;
	assign sts.out_ready = out_ready;

	assign out_valid    = out_valid_q;
	assign inside_res   = inside_q;
	assign dist_squared = dist_q;

endmodule
`default_nettype wire

### rtl/box_kernel_ellipsoid_test_unit.sv
// Top level of the box kernel ellipsoid test unit: stream ports, controller and datapath.
// A selected dimension runs multiply, prepare, check, 28 radix-2 division steps, square
// and accumulate before the next input beat is taken; a term that saturates skips the
// division loop and the square; an unselected dimension runs only the multiply step.
// A last dimension loads its result once the output is free; the beat is valid next cycle.
// Reset (arst_n low) clears the accumulator and control; kernel_factor returns to 1.0.
`default_nettype none
module box_kernel_ellipsoid_test_unit #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// point_coord, center_coord, bandwidth, zero fill
	input  wire logic [((2*COORD_WIDTH+bket_pkg::BW_W+7)/8)*8-1:0] s_tdata,
	// selected
	input  wire logic                            s_tuser,
	input  wire logic                            s_tlast,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// dist_squared
	output logic [bket_pkg::ACC_W-1:0]           m_tdata,
	// inside_res
	output logic                                 m_tuser,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [bket_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bket_pkg::KF_W-1:0]       cfg_data
);

	localparam int IN_W      = 2 * COORD_WIDTH + bket_pkg::BW_W;

	bket_pkg::cmd_t    cmd;
	bket_pkg::status_t sts;

	assign cfg_ready = 1'b1;

	bket_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bket_datapath #(
		.COORD_WIDTH (COORD_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.point_coord  (s_tdata[COORD_WIDTH-1:0]),
		.center_coord (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
		.bandwidth    (s_tdata[IN_W-1:2*COORD_WIDTH]),
		.selected     (s_tuser),
		.last_dim     (s_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.inside_res   (m_tuser),
		.dist_squared (m_tdata)
	);

endmodule
`default_nettype wire

### bench/testbench.sv
// Self-checking bench for the box kernel ellipsoid test unit: stream driver, result monitor, predictor.
`timescale 1ns / 1ps
module testbench;

	localparam int     TDATA_W    = 96;
	localparam int     IDLE_LIMIT = 5000;
	localparam int     SETTLE     = 40;
	localparam int     PHASES     = 8;
	localparam int     PHASE_DIMS = 204;
	localparam longint COORD_MAX  = 64'sd2147483647;
	localparam longint COORD_MIN  = -64'sd2147483648;

	typedef struct {
		logic [31:0] pt;
		logic [31:0] ctr;
		logic [31:0] bw;
		logic        sel;
		logic        last;
	} dim_t;

	typedef struct {
		logic        in_range;
		logic [31:0] dist_sq;
	} result_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           s_tvalid  = 1'b0;
	logic [TDATA_W-1:0]             s_tdata   = '0;
	logic                           s_tuser   = 1'b0;
	logic                           s_tlast   = 1'b0;
	logic                           m_tready  = 1'b0;
	logic                           cfg_valid = 1'b0;
	logic [bket_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [bket_pkg::KF_W-1:0]      cfg_data  = '0;
	logic                           s_tready;
	logic                           m_tvalid;
	logic [bket_pkg::ACC_W-1:0]     m_tdata;
	logic                           m_tuser;
	logic                           cfg_ready;

	// predictor state
	logic [31:0] kf_model   = bket_pkg::KF_RESET;
	logic        incl_model = 1'b0;
	logic [31:0] acc_model  = '0;

	dim_t    dim_q[$];
	result_t due_results[$];
	dim_t    cur_dim;
	result_t got_r;
	result_t exp_r;
	bit      no_idle = 1'b0;
	int      send_gap = 0;
	int      recv_gap = 0;
	int      idle_cycles = 0;
	int      n_queued = 0;
	int      n_sent = 0;
	int      n_points = 0;
	int      n_checked = 0;
	int      n_outside = 0;
	int      n_saturated = 0;
	int      n_on_one = 0;
	int      n_settings = 0;
	int      n_errors = 0;

	box_kernel_ellipsoid_test_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int draw_wait();
		return no_idle ? 0 : int'($urandom_range(0, 11));
	endfunction

	function automatic longint unsigned scaled_bw(input logic [31:0] bw);
		longint unsigned sc;
		sc = (64'(bw) * 64'(kf_model)) >> 16;
		return (sc == 0) ? 64'd1 : sc;
	endfunction

	// squared normalized offset of one dimension, Q8.24
	function automatic logic [31:0] norm_sq(input dim_t d);
		longint          off;
		longint unsigned mag;
		longint unsigned quo;
		off = longint'($signed(d.pt)) - longint'($signed(d.ctr));
		mag = (off < 0) ? longint'(-off) : longint'(off);
		quo = (mag << 24) / scaled_bw(d.bw);
		if (quo >= (64'd1 << 28))
			return bket_pkg::ACC_MAX;
		return 32'((quo * quo) >> 24);
	endfunction

	task automatic accumulate_dim(input dim_t d);
		longint unsigned sum;
		result_t         r;
		if (d.sel) begin
			sum = 64'(acc_model) + 64'(norm_sq(d));
			acc_model = (sum > 64'(bket_pkg::ACC_MAX)) ? bket_pkg::ACC_MAX : sum[31:0];
		end
		if (d.last) begin
			r.dist_sq = acc_model;
			r.in_range = incl_model ? (acc_model < bket_pkg::ACC_ONE)
			                        : (acc_model <= bket_pkg::ACC_ONE);
			due_results.push_back(r);
			acc_model = '0;
		end
	endtask

	task automatic push_dim(input logic [31:0] pt, input logic [31:0] ctr,
			input logic [31:0] bw, input logic sel, input logic last);
		dim_t d;
		d.pt = pt;
		d.ctr = ctr;
		d.bw = bw;
		d.sel = sel;
		d.last = last;
		dim_q.push_back(d);
		n_queued++;
		if (last)
			n_points++;
	endtask

	// random dimension, mostly with the offset up to slightly over one scaled bandwidth
	task automatic push_rand_dim(input logic last);
		logic [31:0] ctr;
		logic [31:0] bw;
		logic [31:0] pt;
		longint      off;
		longint      p;
		ctr = $urandom;
		bw = $urandom >> $urandom_range(0, 31);
		if (bw == 0)
			bw = 32'd1;
		if ($urandom_range(0, 3) == 0) begin
			pt = $urandom;
		end else begin
			off = longint'((scaled_bw(bw) * $urandom_range(0, 1100)) >> 10);
			if ($urandom_range(0, 1))
				off = -off;
			p = longint'($signed(ctr)) + off;
			if (p > COORD_MAX || p < COORD_MIN)
				p = longint'($signed(ctr)) - off;
			if (p > COORD_MAX || p < COORD_MIN)
				p = longint'($signed(ctr));
			pt = p[31:0];
		end
		push_dim(pt, ctr, bw, $urandom_range(0, 4) != 0, last);
	endtask

	task automatic write_reg(input logic [bket_pkg::CFG_IDX_W-1:0] idx,
			input logic [bket_pkg::KF_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == bket_pkg::REG_KERNEL_FACTOR)
			kf_model = val;
		else if (idx == bket_pkg::REG_BOUNDARY)
			incl_model = val[0];
		n_settings++;
	endtask

	// wait until every queued beat is taken and every result is back
	task automatic drain();
		do
			@(posedge clk);
		while (n_sent != n_queued || due_results.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				accumulate_dim(cur_dim);
				n_sent++;
				send_gap = draw_wait();
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap == 0 && dim_q.size() != 0) begin
					cur_dim = dim_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {cur_dim.bw, cur_dim.ctr, cur_dim.pt};
					s_tuser <= cur_dim.sel;
					s_tlast <= cur_dim.last;
				end else begin
					if (send_gap > 0)
						send_gap--;
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_r.dist_sq = m_tdata;
				got_r.in_range = m_tuser;
				if (due_results.size() == 0) begin
					$error("unexpected result beat: dist_squared %h inside_res %b",
						got_r.dist_sq, got_r.in_range);
					n_errors++;
				end else begin
					exp_r = due_results.pop_front();
					if (got_r.dist_sq !== exp_r.dist_sq) begin
						$error("dist_squared: expected %h, got %h",
							exp_r.dist_sq, got_r.dist_sq);
						n_errors++;
					end
					if (got_r.in_range !== exp_r.in_range) begin
						$error("inside_res: expected %b, got %b",
							exp_r.in_range, got_r.in_range);
						n_errors++;
					end
					n_checked++;
					if (!exp_r.in_range)
						n_outside++;
					if (exp_r.dist_sq == bket_pkg::ACC_MAX)
						n_saturated++;
					if (exp_r.dist_sq == bket_pkg::ACC_ONE)
						n_on_one++;
				end
				recv_gap = draw_wait();
			end
			if (recv_gap > 0) begin
				recv_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no beat for %0d cycles", IDLE_LIMIT);
			$display("** box_kernel_ellipsoid_test_unit: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [31:0]     kf_plan[PHASES];
		logic [31:0]     bw;
		longint unsigned sc;
		int              start;
		int              dims;
		kf_plan[0] = bket_pkg::KF_RESET;
		kf_plan[1] = 32'd1;
		kf_plan[2] = 32'hFFFF_FFFF;
		kf_plan[3] = $urandom_range(16384, 262144);
		kf_plan[4] = $urandom;
		kf_plan[5] = 32'h0002_0000;
		kf_plan[6] = $urandom_range(1, 65535);
		kf_plan[7] = $urandom_range(16384, 262144);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: unit factor, boundary counted as inside
		push_dim(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 1'b1, 1'b1);
		push_dim(32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 1'b1, 1'b1);
		push_dim(32'h0001_0001, 32'h0000_0000, 32'h0001_0000, 1'b1, 1'b1);
		push_dim(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b1, 1'b1);
		push_dim(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
		push_dim(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b0, 1'b1);
		push_dim(32'h0000_8000, 32'h0000_0000, 32'h0001_0000, 1'b1, 1'b0);
		push_dim(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0, 1'b0);
		push_dim(32'hFFFF_8000, 32'h0000_0000, 32'h0001_0000, 1'b1, 1'b1);
		// quotient just under sixteen twice overflows the sum, sixteen saturates
		push_dim(32'h000F_FFFF, 32'h0000_0000, 32'h0001_0000, 1'b1, 1'b0);
		push_dim(32'h0000_0000, 32'h000F_FFFF, 32'h0001_0000, 1'b1, 1'b1);
		push_dim(32'h0010_0000, 32'h0000_0000, 32'h0001_0000, 1'b1, 1'b1);
		push_dim(32'h0000_0003, 32'h0000_0000, 32'h0000_0001, 1'b1, 1'b1);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			write_reg(bket_pkg::REG_KERNEL_FACTOR, kf_plan[ph]);
			write_reg(bket_pkg::REG_BOUNDARY, {31'($urandom), ph[0]});
			no_idle = (ph == 2 || ph == 5);
			start = n_queued;
			// exactly one scaled bandwidth, then the smallest bandwidth
			bw = 32'd1 << $urandom_range(0, 16);
			sc = scaled_bw(bw);
			if (sc > 64'h7FFF_FFFF) begin
				bw = 32'd1;
				sc = scaled_bw(bw);
			end
			push_dim(sc[31:0], 32'h0000_0000, bw, 1'b1, 1'b1);
			push_dim(32'hFFFF_FFFD, 32'h0000_0000, 32'h0000_0001, 1'b1, 1'b1);
			while (n_queued - start < PHASE_DIMS) begin
				dims = ($urandom_range(0, 9) == 0) ? 8 : $urandom_range(1, 4);
				for (int k = 1; k <= dims; k++)
					push_rand_dim(k == dims);
			end
			drain();
		end

		$display("%0d dimensions in %0d points; %0d results checked, %0d outside,",
			n_sent, n_points, n_checked, n_outside);
		$display("%0d saturated, %0d at exactly one; %0d register writes, both boundary modes",
			n_saturated, n_on_one, n_settings);
		if (n_errors == 0)
			$display("** box_kernel_ellipsoid_test_unit: PASSED **");
		else
			$display("** box_kernel_ellipsoid_test_unit: FAILED **");
		$finish;
	end

endmodule
